// ----- hdl/knn_pkg.sv -----
// Shared types and constants for the nearest neighbor distance engine.
package knn_pkg;

   localparam int unsigned DIST_W = 36;

   // Configuration register indexes
   localparam logic [1:0] REG_METRIC = 2'd0;
   localparam logic [1:0] REG_KEEP   = 2'd1;
   localparam logic [1:0] REG_DIMS   = 2'd2;
   localparam logic [1:0] REG_REFS   = 2'd3;

   // Metric codes
   localparam logic [1:0] MET_SAD = 2'd0;
   localparam logic [1:0] MET_SSD = 2'd1;
   localparam logic [1:0] MET_MAX = 2'd2;
   localparam logic [1:0] MET_MIN = 2'd3;

   localparam logic REQ_REF   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_EMIT,
      ST_OUT
   } state_type;

   // One queued command from front to back
   typedef struct packed {
      logic        req_type;
      logic [5:0]  point_index;
      logic [3:0]  coord_index;
      logic [15:0] coord_value;
      logic        query_last;
   } cmd_type;

endpackage

// ----- hdl/knn_if.sv -----
// Valid/ready channel interfaces for request, response and register writes.
interface knn_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [5:0]  point_index;
   logic [3:0]  coord_index;
   logic [15:0] coord_value;
   logic        query_last;
   modport source (output valid, req_type, point_index, coord_index, coord_value,
      query_last, input ready);
   modport sink (input valid, req_type, point_index, coord_index, coord_value,
      query_last, output ready);
endinterface

interface knn_rsp_if;
   logic        valid;
   logic        ready;
   logic [35:0] dist_value;
   logic [5:0]  ref_number;
   logic        last_result;
   modport source (output valid, dist_value, ref_number, last_result, input ready);
   modport sink (input valid, dist_value, ref_number, last_result, output ready);
endinterface

interface knn_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [6:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/knn_ram.sv -----
// Generic single-port-write, registered-read RAM.
module knn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and read with registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- hdl/knn_queue.sv -----
// Front end: accept items into a short queue in front of the search engine.
module knn_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  knn_pkg::cmd_type  in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output knn_pkg::cmd_type  out_cmd
);
   localparam int AW = $clog2(DEPTH);
   knn_pkg::cmd_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_cmd;
      end
   end
endmodule

// ----- hdl/knn_engine.sv -----
// Back end: store coordinates, walk references, keep the best list, emit items.
module knn_engine #(
   parameter int NUM_REFS = 64,
   parameter int NUM_DIMS = 16,
   parameter int MAX_KEEP = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  knn_pkg::cmd_type  cmd,
   input  logic [1:0]        metric_mode,
   input  logic [4:0]        keep_count,
   input  logic [4:0]        dims_in_use,
   input  logic [6:0]        ref_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [35:0]       rsp_dist,
   output logic [5:0]        rsp_ref,
   output logic              rsp_last
);
   localparam int RW = (NUM_REFS > 1) ? $clog2(NUM_REFS) : 1;
   localparam int DW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
   localparam int KW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int AW = RW + DW;
   localparam int DEPTH = 2 ** AW;
   localparam int QDEPTH = 2 ** DW;
   localparam logic [36:0] EMPTY = '1;
   localparam logic [35:0] DMAX = '1;

   knn_pkg::state_type st_ff, st_in;

   // Walk counters
   logic [RW:0] refs, rcnt_ff, rcnt_in;
   logic [DW:0] dims, dcnt_ff, dcnt_in;
   logic [6:0]  keep;
   logic [KW:0] ocnt_ff, ocnt_in;
   logic        all_mode;

   // Store ports
   logic          ref_we, qry_we;
   logic [AW-1:0] ref_wa, ref_ra;
   logic [15:0]   ref_rd, qry_rd;
   logic [DW-1:0] qry_wa;

   // Pipeline: read issue -> data -> abs diff -> square -> accumulate
   logic          v1_ff, v2_ff, v3_ff;
   logic          f1_ff, f2_ff, f3_ff, l1_ff, l2_ff, l3_ff;
   logic [RW-1:0] r1_ff, r2_ff, r3_ff;
   logic [16:0]   a2_ff, a3_ff;
   logic [33:0]   t3_ff;
   logic [36:0]   acc_ff, acc_in;
   logic          dv_ff;
   logic [RW-1:0] dr_ff;

   logic [36:0]   bd_ff [MAX_KEEP];
   logic [RW-1:0] bi_ff [MAX_KEEP];

   logic [35:0] od_ff;
   logic [5:0]  or_ff;
   logic        ol_ff, ov_ff, ov_in;

   // Clamp register values
   always_comb begin
      if (dims_in_use == 5'd0) dims = (DW+1)'(1);
      else if (32'(dims_in_use) > NUM_DIMS) dims = (DW+1)'(NUM_DIMS);
      else dims = (DW+1)'(dims_in_use);
      if (ref_count == 7'd0) refs = (RW+1)'(1);
      else if (32'(ref_count) > NUM_REFS) refs = (RW+1)'(NUM_REFS);
      else refs = (RW+1)'(ref_count);
      keep = 7'(keep_count);
      if (32'(keep) > MAX_KEEP) keep = 7'(MAX_KEEP);
      if (keep > 7'(refs)) keep = 7'(refs);
      all_mode = (keep_count == 5'd0);
   end

   // Store writes from queued commands
   assign cmd_ready = (st_ff == knn_pkg::ST_IDLE);
   always_comb begin
      ref_we = cmd_valid && cmd_ready && cmd.req_type == knn_pkg::REQ_REF
         && 32'(cmd.point_index) < NUM_REFS && 32'(cmd.coord_index) < NUM_DIMS;
      qry_we = cmd_valid && cmd_ready && cmd.req_type == knn_pkg::REQ_QUERY
         && 32'(cmd.coord_index) < NUM_DIMS;
      ref_wa = AW'(32'(cmd.point_index) * NUM_DIMS + 32'(cmd.coord_index));
      qry_wa = DW'(cmd.coord_index);
      ref_ra = AW'(32'(rcnt_ff[RW-1:0]) * NUM_DIMS + 32'(dcnt_ff[DW-1:0]));
   end

   knn_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ref (
      .clock(clock), .wr_en(ref_we), .wr_addr(ref_wa), .wr_data(cmd.coord_value),
      .rd_addr(ref_ra), .rd_data(ref_rd));
   knn_ram #(.WIDTH(16), .DEPTH(QDEPTH)) u_qry (
      .clock(clock), .wr_en(qry_we), .wr_addr(qry_wa), .wr_data(cmd.coord_value),
      .rd_addr(dcnt_ff[DW-1:0]), .rd_data(qry_rd));

   logic issue, rd_last, pipe_busy, slot_free, go;
   assign issue = (st_ff == knn_pkg::ST_READ);
   assign rd_last = (dcnt_ff == dims - 1'b1);
   assign pipe_busy = v1_ff || v2_ff || v3_ff || dv_ff;
   assign slot_free = !ov_ff || rsp_ready;

   // In all-distance mode start a reference only with the pipeline empty and the output slot empty
   assign go = issue && (!all_mode || dcnt_ff != '0 || (!ov_ff && !pipe_busy));

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         knn_pkg::ST_IDLE:
            if (cmd_valid && cmd.req_type == knn_pkg::REQ_QUERY && cmd.query_last)
               st_in = knn_pkg::ST_READ;
         knn_pkg::ST_READ:
            if (go && rd_last && rcnt_ff == refs - 1'b1)
               st_in = knn_pkg::ST_DRAIN;
         knn_pkg::ST_DRAIN:
            if (!pipe_busy) st_in = all_mode ? knn_pkg::ST_IDLE : knn_pkg::ST_EMIT;
         knn_pkg::ST_EMIT:
            if (slot_free && ocnt_ff == (KW+1)'(keep - 7'd1))
               st_in = knn_pkg::ST_IDLE;
         default: st_in = knn_pkg::ST_IDLE;
      endcase
   end

   // Counters
   always_comb begin
      rcnt_in = rcnt_ff;
      dcnt_in = dcnt_ff;
      ocnt_in = ocnt_ff;
      if (st_ff == knn_pkg::ST_IDLE) begin
         rcnt_in = '0;
         dcnt_in = '0;
         ocnt_in = '0;
      end else if (go) begin
         if (rd_last) begin
            dcnt_in = '0;
            if (rcnt_ff != refs - 1'b1) rcnt_in = rcnt_ff + 1'b1;
         end else begin
            dcnt_in = dcnt_ff + 1'b1;
         end
      end else if (st_ff == knn_pkg::ST_EMIT && slot_free) begin
         ocnt_in = ocnt_ff + 1'b1;
      end
   end

   // Output slot: release on accept, load on a new item
   always_comb begin
      ov_in = ov_ff && !rsp_ready;
      if ((dv_ff && all_mode) || (st_ff == knn_pkg::ST_EMIT && slot_free)) ov_in = 1'b1;
   end

   // Accumulate per metric
   logic [36:0] term;
   always_comb begin
      term = (metric_mode == knn_pkg::MET_SSD) ? 37'(t3_ff) : 37'(a3_ff);
      acc_in = acc_ff;
      case (metric_mode)
         knn_pkg::MET_SAD, knn_pkg::MET_SSD: acc_in = (f3_ff ? 37'd0 : acc_ff) + term;
         knn_pkg::MET_MAX: acc_in = (f3_ff || term > acc_ff) ? term : acc_ff;
         knn_pkg::MET_MIN: acc_in = (f3_ff || term < acc_ff) ? term : acc_ff;
         default: acc_in = acc_ff;
      endcase
   end

   logic [36:0] dsat;
   assign dsat = (acc_ff > 37'(DMAX)) ? 37'(DMAX) : acc_ff;

   // Insertion position into the sorted best list
   logic [MAX_KEEP-1:0] gt;
   always_comb begin
      for (int i = 0; i < MAX_KEEP; i++) begin
         gt[i] = (i < 32'(keep)) && (bd_ff[i] > dsat);
      end
   end

   logic [16:0] diff;
   assign diff = 17'($signed({ref_rd[15], ref_rd}) - $signed({qry_rd[15], qry_rd}));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= knn_pkg::ST_IDLE;
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; dv_ff <= 1'b0;
         ov_ff <= 1'b0;
         rcnt_ff <= '0; dcnt_ff <= '0; ocnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         rcnt_ff <= rcnt_in; dcnt_ff <= dcnt_in; ocnt_ff <= ocnt_in;
         v1_ff <= go;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         dv_ff <= v3_ff && l3_ff;
         ov_ff <= ov_in;
      end
      // Payload pipeline
      f1_ff <= (dcnt_ff == '0); l1_ff <= rd_last; r1_ff <= rcnt_ff[RW-1:0];
      f2_ff <= f1_ff; l2_ff <= l1_ff; r2_ff <= r1_ff;
      a2_ff <= diff[16] ? 17'(-$signed(diff)) : diff;
      f3_ff <= f2_ff; l3_ff <= l2_ff; r3_ff <= r2_ff;
      a3_ff <= a2_ff;
      t3_ff <= 34'(a2_ff) * 34'(a2_ff);
      if (v3_ff) acc_ff <= acc_in;
      dr_ff <= r3_ff;
      // Best list: clear at search start, insert each finished distance unless in all-distance mode
      if (st_ff == knn_pkg::ST_IDLE) begin
         for (int i = 0; i < MAX_KEEP; i++) begin
            bd_ff[i] <= EMPTY;
            bi_ff[i] <= '0;
         end
      end else if (dv_ff && !all_mode) begin
         for (int i = 0; i < MAX_KEEP; i++) begin
            if (gt[i]) begin
               if (i == 0 || !gt[(i == 0) ? 0 : i-1]) begin
                  bd_ff[i] <= dsat;
                  bi_ff[i] <= dr_ff;
               end else begin
                  bd_ff[i] <= bd_ff[(i == 0) ? 0 : i-1];
                  bi_ff[i] <= bi_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
      end
      // Output register
      if (dv_ff && all_mode) begin
         od_ff <= dsat[35:0];
         or_ff <= 6'(dr_ff);
         ol_ff <= ((RW+1)'(dr_ff) == refs - 1'b1);
      end else if (st_ff == knn_pkg::ST_EMIT && slot_free) begin
         od_ff <= bd_ff[ocnt_ff[KW-1:0]][35:0];
         or_ff <= 6'(bi_ff[ocnt_ff[KW-1:0]]);
         ol_ff <= (ocnt_ff == (KW+1)'(keep - 7'd1));
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_dist  = od_ff;
   assign rsp_ref   = or_ff;
   assign rsp_last  = ol_ff;
endmodule

// ----- hdl/knn_distance_engine.sv -----
// Top level of the nearest neighbor distance engine.
// A coordinate item is written to its store when the engine, while idle, takes it from the queue.
// With keep_count nonzero a search reads N = ref_count*dims_in_use coordinates, one per
// cycle; once the pipeline drains the results follow, one per cycle while rsp.ready holds.
// With keep_count zero one distance is in flight: a reference starts once the pipeline is empty.
// Reset (synchronous, active high) clears control and registers to defaults.
module knn_distance_engine #(
   parameter int NUM_REFS = 64,
   parameter int NUM_DIMS = 16,
   parameter int MAX_KEEP = 16
) (
   input  logic clock,
   input  logic reset,
   knn_req_if.sink   req,
   knn_rsp_if.source rsp,
   knn_csr_if.sink   csr
);
   logic [1:0] metric_ff;
   logic [4:0] keep_ff, dims_ff;
   logic [6:0] refs_ff;
   knn_pkg::cmd_type in_cmd, q_cmd;
   logic q_valid, q_ready;

   // Register writes
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= 2'd0; keep_ff <= 5'd0; dims_ff <= 5'd16; refs_ff <= 7'd64;
      end else if (csr.valid) begin
         case (csr.index)
            knn_pkg::REG_METRIC: metric_ff <= csr.data[1:0];
            knn_pkg::REG_KEEP:   keep_ff <= csr.data[4:0];
            knn_pkg::REG_DIMS:   dims_ff <= csr.data[4:0];
            knn_pkg::REG_REFS:   refs_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign in_cmd = '{req_type: req.req_type, point_index: req.point_index,
      coord_index: req.coord_index, coord_value: req.coord_value,
      query_last: req.query_last};

   knn_queue #(.DEPTH(4)) u_queue (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .in_cmd(in_cmd), .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd));

   knn_engine #(.NUM_REFS(NUM_REFS), .NUM_DIMS(NUM_DIMS), .MAX_KEEP(MAX_KEEP)) u_eng (
      .clock(clock), .reset(reset), .cmd_valid(q_valid), .cmd_ready(q_ready),
      .cmd(q_cmd), .metric_mode(metric_ff), .keep_count(keep_ff),
      .dims_in_use(dims_ff), .ref_count(refs_ff), .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready), .rsp_dist(rsp.dist_value), .rsp_ref(rsp.ref_number),
      .rsp_last(rsp.last_result));

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.dist_value))
      else $error("result dropped while stalled");
   a_cfg: assert property (@(posedge clock) disable iff (reset)
      csr.valid && csr.index == knn_pkg::REG_DIMS |=> dims_ff == $past(csr.data[4:0]))
      else $error("register write lost");
`endif
endmodule
